// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the gauge RTL.
// Both expect clk_i and rst_ni to exist in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define BLG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BLG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/blg_pkg.sv =====
`default_nettype none

package blg_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SUPPLY_W = 16;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned PHASE_W  = 7;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Serial divider sizes: the dividend register holds the reference constant or
  // the shifted mapping difference, the remainder is as wide as the largest divisor.
  localparam int unsigned DVD_W   = 23;
  localparam int unsigned REM_W   = 12;
  localparam int unsigned STEP_W  = 5;

  // Supply in mV is REF_DIVIDEND / sample (4096 codes times 1200 mV).
  localparam logic [DVD_W-1:0] REF_DIVIDEND = 23'd4915200;
  // Samples at or below this give a quotient above the 16-bit range.
  localparam logic [SAMPLE_W-1:0] SAT_SAMPLE = 12'(REF_DIVIDEND >> 16);
  localparam logic [SUPPLY_W-1:0] SUPPLY_SAT = 16'hFFFF;
  localparam logic [STEP_W-1:0]   SUP_STEPS  = 5'd23;
  localparam logic [STEP_W-1:0]   MAP_STEPS  = 5'd16;

  // Level mapping.
  localparam logic [REM_W-1:0]   MAP_DIV_LOW  = 12'd80;
  localparam logic [REM_W-1:0]   MAP_DIV_KNEE = 12'd6;
  localparam logic [16:0]        KNEE_BASE    = 17'd20;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 7'd99;
  localparam logic [LEVEL_W-1:0] FALL_SPLIT   = 7'd40;
  localparam logic [LEVEL_W-1:0] LEVEL_EMPTY  = 7'd1;

  // Timing.
  localparam logic [COUNT_W-1:0] STARTUP_TICKS    = 8'd200;
  localparam logic [PHASE_W-1:0] TICKS_PER_SECOND = 7'd100;

  // Register reset values.
  localparam logic [CFG_W-1:0]   LOW_MV_RST     = 16'd2800;
  localparam logic [CFG_W-1:0]   KNEE_MV_RST    = 16'd3600;
  localparam logic [CFG_W-1:0]   RISE_IV_RST    = 16'd15000;
  localparam logic [CFG_W-1:0]   FALL_HI_IV_RST = 16'd15000;
  localparam logic [CFG_W-1:0]   FALL_LO_IV_RST = 16'd8000;
  localparam logic [CFG_W-1:0]   FULL_IV_RST    = 16'd7500;
  localparam logic [COUNT_W-1:0] LOCK_TICKS_RST = 8'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_MV     = 3'd0,
    CFG_KNEE_MV    = 3'd1,
    CFG_RISE_IV    = 3'd2,
    CFG_FALL_HI_IV = 3'd3,
    CFG_FALL_LO_IV = 3'd4,
    CFG_FULL_IV    = 3'd5,
    CFG_LOCK_TICKS = 3'd6
  } blg_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUP,
    ST_PREP,
    ST_MAP,
    ST_FINAL
  } blg_state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ref_sample;
    logic                sample_valid;
    logic                charging;
    logic                charge_full;
  } blg_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  shown_level;
    logic [LEVEL_W-1:0]  raw_level;
    logic [SUPPLY_W-1:0] supply_mv;
    logic                low_lock;
  } blg_out_t;

  // Divider control and status.
  typedef struct packed {
    logic                load;
    logic [DVD_W-1:0]    dividend;
    logic [REM_W-1:0]    divisor;
    logic [STEP_W-1:0]   steps;
  } blg_div_ctrl_t;

  typedef struct packed {
    logic                busy;
    logic [SUPPLY_W-1:0] quotient;
  } blg_div_stat_t;

endpackage

`default_nettype wire

// ===== sv/blg_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is shifted in
// MSB first; only the low 16 quotient bits are kept.
module blg_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire blg_pkg::blg_div_ctrl_t ctrl_i,
  output blg_pkg::blg_div_stat_t      stat_o
);

  logic [blg_pkg::DVD_W-1:0]    dvd_q;
  logic [blg_pkg::REM_W-1:0]    dsr_q;
  logic [blg_pkg::REM_W-1:0]    rem_q;
  logic [blg_pkg::SUPPLY_W-1:0] quo_q;
  logic [blg_pkg::STEP_W-1:0]   cnt_q;

  logic [blg_pkg::REM_W:0]      trial;
  logic                         fits;
  logic [blg_pkg::REM_W-1:0]    rem_step;

  // One trial subtraction per cycle.
  always_comb begin
    trial    = {rem_q, dvd_q[blg_pkg::DVD_W-1]};
    fits     = trial >= {1'b0, dsr_q};
    rem_step = fits ? blg_pkg::REM_W'(trial - {1'b0, dsr_q})
                    : trial[blg_pkg::REM_W-1:0];
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      cnt_q <= ctrl_i.steps;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      dvd_q <= ctrl_i.dividend;
      dsr_q <= ctrl_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[blg_pkg::DVD_W-2:0], 1'b0};
      rem_q <= rem_step;
      quo_q <= {quo_q[blg_pkg::SUPPLY_W-2:0], fits};
    end
  end

  assign stat_o.busy     = cnt_q != '0;
  assign stat_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== sv/battery_level_gauge_top.sv =====
// Flow: a word with a new in-range sample passes the supply division (ST_SUP),
// others skip it; then ST_PREP, the level division (ST_MAP) unless the supply
// is under the low threshold, and ST_FINAL. One word at a time, taken the cycle
// after the previous result is registered; both divisions use the shared
// one-bit-per-cycle divider, and a stalled result holds the next word back.
// Reset: asynchronous, active low; state registers return to defaults at once.
`default_nettype none

module battery_level_gauge_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [blg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [blg_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire blg_pkg::blg_in_t                  in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output blg_pkg::blg_out_t                      out_data_o
);

  `include "assert_macros.svh"

  // Configuration registers.
  logic [blg_pkg::CFG_W-1:0]   low_mv_q, knee_mv_q, rise_iv_q;
  logic [blg_pkg::CFG_W-1:0]   fall_hi_iv_q, fall_lo_iv_q, full_iv_q;
  logic [blg_pkg::COUNT_W-1:0] lock_ticks_q;

  // Gauge state.
  blg_pkg::blg_state_e state_q, state_d;
  blg_pkg::blg_in_t    item_q, item_d;
  blg_pkg::blg_out_t   out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                steep_q, steep_d;
  logic [blg_pkg::SUPPLY_W-1:0] supply_q, supply_d;
  logic [blg_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic [blg_pkg::COUNT_W-1:0]  under_cnt_q, under_cnt_d;
  logic                         lock_q, lock_d;
  logic [blg_pkg::LEVEL_W-1:0]  raw_q, raw_d;
  logic [blg_pkg::LEVEL_W-1:0]  shown_q, shown_d;
  logic [blg_pkg::CFG_W-1:0]    creep_q, creep_d;
  logic [blg_pkg::CFG_W-1:0]    track_q, track_d;
  logic [blg_pkg::COUNT_W-1:0]  startup_q, startup_d;

  blg_pkg::blg_div_ctrl_t div_ctrl;
  blg_pkg::blg_div_stat_t div_stat;

  // Tick update terms.
  logic [blg_pkg::PHASE_W-1:0]  phase_inc, phase_nxt;
  logic                         under;
  logic [blg_pkg::COUNT_W-1:0]  under_inc;
  logic                         lock_hit, lock_nxt;
  logic [16:0]                  map_sum;
  logic [blg_pkg::LEVEL_W-1:0]  raw_map;
  logic                         full;
  logic [blg_pkg::CFG_W-1:0]    creep_inc, track_inc, fall_iv;
  logic                         creep_go, creep_hit;
  logic [blg_pkg::LEVEL_W-1:0]  shown_c;
  logic                         rise_go, rise_hit, fall_go, fall_hit;
  logic [blg_pkg::LEVEL_W-1:0]  shown_t, raw_t;
  logic [blg_pkg::SUPPLY_W-1:0] map_diff;

  blg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .stat_o (div_stat)
  );

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_mv_q     <= blg_pkg::LOW_MV_RST;
      knee_mv_q    <= blg_pkg::KNEE_MV_RST;
      rise_iv_q    <= blg_pkg::RISE_IV_RST;
      fall_hi_iv_q <= blg_pkg::FALL_HI_IV_RST;
      fall_lo_iv_q <= blg_pkg::FALL_LO_IV_RST;
      full_iv_q    <= blg_pkg::FULL_IV_RST;
      lock_ticks_q <= blg_pkg::LOCK_TICKS_RST;
    end else if (cfg_we_i) begin
      case (blg_pkg::blg_cfg_e'(cfg_idx_i))
        blg_pkg::CFG_LOW_MV:     low_mv_q     <= cfg_wdata_i;
        blg_pkg::CFG_KNEE_MV:    knee_mv_q    <= cfg_wdata_i;
        blg_pkg::CFG_RISE_IV:    rise_iv_q    <= cfg_wdata_i;
        blg_pkg::CFG_FALL_HI_IV: fall_hi_iv_q <= cfg_wdata_i;
        blg_pkg::CFG_FALL_LO_IV: fall_lo_iv_q <= cfg_wdata_i;
        blg_pkg::CFG_FULL_IV:    full_iv_q    <= cfg_wdata_i;
        blg_pkg::CFG_LOCK_TICKS: lock_ticks_q <= cfg_wdata_i[blg_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-tick arithmetic used when the word is finished.
  always_comb begin
    phase_inc = phase_q + 7'd1;
    phase_nxt = (phase_inc >= blg_pkg::TICKS_PER_SECOND) ? '0 : phase_inc;

    under     = supply_q < low_mv_q;
    under_inc = under_cnt_q + 8'd1;
    lock_hit  = under && (under_inc > lock_ticks_q);
    lock_nxt  = lock_q || lock_hit;

    map_sum = {1'b0, div_stat.quotient} + (steep_q ? blg_pkg::KNEE_BASE : 17'd0);
    raw_map = (map_sum > 17'(blg_pkg::LEVEL_MAX)) ? blg_pkg::LEVEL_MAX
                                                   : map_sum[blg_pkg::LEVEL_W-1:0];

    full      = item_q.charging && item_q.charge_full;
    creep_inc = creep_q + 16'd1;
    track_inc = track_q + 16'd1;

    // Creep toward full, then track the raw level upward.
    creep_go  = full && (shown_q < blg_pkg::LEVEL_MAX);
    creep_hit = creep_go && (creep_inc >= full_iv_q);
    shown_c   = shown_q + {6'd0, creep_hit};
    rise_go   = raw_map > shown_c;
    rise_hit  = rise_go && (track_inc >= rise_iv_q) && (shown_c < blg_pkg::LEVEL_MAX);

    // Track the raw level downward while discharging.
    fall_iv  = (shown_q < blg_pkg::FALL_SPLIT) ? fall_lo_iv_q : fall_hi_iv_q;
    fall_go  = (raw_map < shown_q) && (shown_q > blg_pkg::LEVEL_EMPTY);
    fall_hit = fall_go && (track_inc >= fall_iv);

    // Mapping segment chosen from the fresh supply value.
    map_diff = (supply_q >= knee_mv_q) ? (supply_q - knee_mv_q) : (supply_q - low_mv_q);
  end

  // Sequencer: next state, divider control and state updates.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    steep_d     = steep_q;
    supply_d    = supply_q;
    phase_d     = phase_q;
    under_cnt_d = under_cnt_q;
    lock_d      = lock_q;
    raw_d       = raw_q;
    shown_d     = shown_q;
    creep_d     = creep_q;
    track_d     = track_q;
    startup_d   = startup_q;
    shown_t     = shown_q;
    raw_t       = raw_q;
    div_ctrl    = '0;
    in_ready_o  = state_q == blg_pkg::ST_IDLE;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      blg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          if (in_data_i.sample_valid) begin
            if (in_data_i.ref_sample <= blg_pkg::SAT_SAMPLE) begin
              supply_d = blg_pkg::SUPPLY_SAT;
              state_d  = blg_pkg::ST_PREP;
            end else begin
              div_ctrl.load     = 1'b1;
              div_ctrl.dividend = blg_pkg::REF_DIVIDEND;
              div_ctrl.divisor  = in_data_i.ref_sample;
              div_ctrl.steps    = blg_pkg::SUP_STEPS;
              state_d           = blg_pkg::ST_SUP;
            end
          end else begin
            state_d = blg_pkg::ST_PREP;
          end
        end
      end

      blg_pkg::ST_SUP: begin
        if (!div_stat.busy) begin
          supply_d = div_stat.quotient;
          state_d  = blg_pkg::ST_PREP;
        end
      end

      blg_pkg::ST_PREP: begin
        if (under) begin
          state_d = blg_pkg::ST_FINAL;
        end else begin
          steep_d           = supply_q >= knee_mv_q;
          div_ctrl.load     = 1'b1;
          div_ctrl.dividend = {map_diff, 7'd0};
          div_ctrl.divisor  = (supply_q >= knee_mv_q) ? blg_pkg::MAP_DIV_KNEE
                                                      : blg_pkg::MAP_DIV_LOW;
          div_ctrl.steps    = blg_pkg::MAP_STEPS;
          state_d           = blg_pkg::ST_MAP;
        end
      end

      blg_pkg::ST_MAP: begin
        if (!div_stat.busy) begin
          state_d = blg_pkg::ST_FINAL;
        end
      end

      blg_pkg::ST_FINAL: begin
        if (!out_valid_q || out_ready_i) begin
          phase_d = phase_nxt;

          // Undervoltage counting and lock.
          if (under) begin
            under_cnt_d = lock_hit ? '0 : under_inc;
          end else begin
            under_cnt_d = '0;
          end
          lock_d = lock_nxt;

          // Level update.
          if (lock_nxt) begin
            shown_t = '0;
            raw_t   = '0;
          end else if (under) begin
            raw_t = blg_pkg::LEVEL_EMPTY;
            if (phase_nxt == '0) begin
              if (shown_q > blg_pkg::LEVEL_EMPTY) begin
                if (!item_q.charging) begin
                  shown_t = shown_q - 7'd1;
                end
              end else begin
                shown_t = blg_pkg::LEVEL_EMPTY;
              end
            end
          end else begin
            raw_t = raw_map;
            if (item_q.charging) begin
              creep_d = creep_go ? (creep_hit ? '0 : creep_inc) : '0;
              track_d = rise_go ? (rise_hit ? '0 : track_inc) : '0;
              shown_t = shown_c + {6'd0, rise_hit};
            end else begin
              track_d = fall_go ? (fall_hit ? '0 : track_inc) : '0;
              shown_t = shown_q - {6'd0, fall_hit};
            end
          end

          // Start-up snap upward.
          if (startup_q != '0) begin
            startup_d = startup_q - 8'd1;
            if (shown_t < raw_t) begin
              shown_t = raw_t;
            end
          end

          shown_d           = shown_t;
          raw_d             = raw_t;
          out_d.shown_level = shown_t;
          out_d.raw_level   = raw_t;
          out_d.supply_mv   = supply_q;
          out_d.low_lock    = lock_nxt;
          out_valid_d       = 1'b1;
          state_d           = blg_pkg::ST_IDLE;
        end
      end

      default: state_d = blg_pkg::ST_IDLE;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      supply_q    <= '0;
      phase_q     <= '0;
      under_cnt_q <= '0;
      lock_q      <= 1'b0;
      raw_q       <= '0;
      shown_q     <= '0;
      creep_q     <= '0;
      track_q     <= '0;
      startup_q   <= blg_pkg::STARTUP_TICKS;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      supply_q    <= supply_d;
      phase_q     <= phase_d;
      under_cnt_q <= under_cnt_d;
      lock_q      <= lock_d;
      raw_q       <= raw_d;
      shown_q     <= shown_d;
      creep_q     <= creep_d;
      track_q     <= track_d;
      startup_q   <= startup_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    out_q   <= out_d;
    steep_q <= steep_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BLG_ASSERT_ALWAYS(a_level_range, out_valid_q |-> (out_q.shown_level <= blg_pkg::LEVEL_MAX && out_q.raw_level <= blg_pkg::LEVEL_MAX), "Level word out of range.")
  `BLG_ASSERT(a_lock_sticky, lock_q |=> lock_q, "Low-battery lock cleared without reset.")
  `BLG_ASSERT(a_lock_zero, (out_valid_q && out_q.low_lock) |-> (out_q.shown_level == '0 && out_q.raw_level == '0), "Locked word shows a nonzero level.")
  `BLG_ASSERT(a_div_quiet, (state_q == blg_pkg::ST_IDLE || state_q == blg_pkg::ST_FINAL) |-> !div_stat.busy, "Divider still busy outside a division.")
  `BLG_ASSERT(a_accept_leaves, (in_valid_i && in_ready_o) |=> (state_q != blg_pkg::ST_IDLE), "Accepted word did not start.")

endmodule

`default_nettype wire
